// ===== sv/tkss_pkg.sv =====
// ----------------------------------------------------------------------------
// tkss_pkg - top-k sampler shared types and constants
// Exponential table for the weight unit and field widths.
// ----------------------------------------------------------------------------
package tkss_pkg;

    localparam int LOGIT_W = 16;
    localparam int DRAW_W  = 16;
    localparam int TOKEN_W = 16;
    localparam int TOPK_W  = 7;
    localparam int WGT_W   = 16;
    localparam int EXP_W   = 33;

    typedef logic [EXP_W-1:0] etab_t [257];

    // restoring shift/subtract quotient, elaboration use only
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= 65'(den))
            begin
                rem    = rem - 65'(den);
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-t/256) in Q1.32, truncated Taylor series, built at elaboration
    function automatic etab_t build_exp_table();
        etab_t       tab;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        for (int t = 0; t <= 256; t++)
        begin
            term = 64'd1 << 32;
            pos  = term;
            neg  = 64'd0;
            for (int n = 1; n <= 13; n++)
            begin
                term = udiv64(term * 64'(t), 64'(n) << 8);
                if ((n & 1) != 0)
                    neg = neg + term;
                else
                    pos = pos + term;
            end
            tab[t] = EXP_W'(pos - neg);
        end
        return tab;
    endfunction

    localparam etab_t EXP_TAB = build_exp_table();

endpackage

// ===== sv/tkss_store.sv =====
// ----------------------------------------------------------------------------
// tkss_store - logit and position store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tkss_store
    import tkss_pkg::*;
#(
    parameter int MAX_ITEMS = 65536,
    localparam int AW = $clog2(MAX_ITEMS)
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [LOGIT_W-1:0] wvalue,
    input  logic [TOKEN_W-1:0] windex,
    input  logic [AW-1:0]      raddr,
    output logic [LOGIT_W-1:0] rvalue,
    output logic [TOKEN_W-1:0] rindex
);

    logic [LOGIT_W-1:0] value_mem [MAX_ITEMS];
    logic [TOKEN_W-1:0] index_mem [MAX_ITEMS];
    logic [LOGIT_W-1:0] rvalue_reg;
    logic [TOKEN_W-1:0] rindex_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            value_mem[waddr] <= wvalue;
            index_mem[waddr] <= windex;
        end
        rvalue_reg <= value_mem[raddr];
        rindex_reg <= index_mem[raddr];
    end

    assign rvalue = rvalue_reg;
    assign rindex = rindex_reg;

endmodule

// ===== sv/tkss_exp.sv =====
// ----------------------------------------------------------------------------
// tkss_exp - iterative exponential weight unit
// exp(-d) in Q0.16 by table seed and repeated multiply by exp(-1),
// one split 33x32 multiply per step, taken in states E_CHECK, E_MLO, E_MHI and E_ADD.
// ----------------------------------------------------------------------------
module tkss_exp
    import tkss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [15:0]      delta,
    output logic             busy,
    output logic             done,
    output logic [WGT_W-1:0] weight
);

    localparam logic [2:0] E_IDLE  = 3'd0;
    localparam logic [2:0] E_CHECK = 3'd1;
    localparam logic [2:0] E_MLO   = 3'd2;
    localparam logic [2:0] E_MHI   = 3'd3;
    localparam logic [2:0] E_ADD   = 3'd4;
    localparam logic [2:0] E_ROUND = 3'd5;

    localparam logic [31:0] E1 = EXP_TAB[256][31:0];

    logic [2:0]       state_reg, state_next;
    logic [EXP_W-1:0] w_reg, w_next;
    logic [7:0]       q_reg, q_next;
    logic [47:0]      plo_reg, plo_next;
    logic [48:0]      phi_reg, phi_next;
    logic [64:0]      sum;
    logic [17:0]      rounded;

    assign sum     = {phi_reg, 16'd0} + 65'(plo_reg);
    assign rounded = 18'((34'(w_reg) + 34'd32768) >> 16);

    always_comb
    begin
        state_next = state_reg;
        w_next     = w_reg;
        q_next     = q_reg;
        plo_next   = plo_reg;
        phi_next   = phi_reg;
        done       = 1'b0;
        unique case (state_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    w_next     = EXP_TAB[delta[7:0]];
                    q_next     = delta[15:8];
                    state_next = E_CHECK;
                end
            end
            E_CHECK:
            begin
                if (q_reg == 8'd0 || w_reg == '0)
                    state_next = E_ROUND;
                else
                    state_next = E_MLO;
            end
            E_MLO:
            begin
                plo_next   = 48'(w_reg[15:0]) * 48'(E1);
                state_next = E_MHI;
            end
            E_MHI:
            begin
                phi_next   = 49'(w_reg[32:16]) * 49'(E1);
                state_next = E_ADD;
            end
            E_ADD:
            begin
                w_next     = sum[64:32];
                q_next     = q_reg - 8'd1;
                state_next = E_CHECK;
            end
            E_ROUND:
            begin
                done       = 1'b1;
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= E_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        q_reg   <= q_next;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
    end

    assign busy   = (state_reg != E_IDLE);
    assign weight = (rounded > 18'd65535) ? 16'hFFFF : rounded[15:0];

endmodule

// ===== sv/topk_softmax_sampler_top.sv =====
// ----------------------------------------------------------------------------
// topk_softmax_sampler_top - top-k softmax token sampler
// Stores a logit vector, sorts out the k best by selection passes, weights
// them by exp((v - max)/256) and picks a token against a random draw.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   logit, random_draw, last_item
//  out      source     out_valid / out_ready token_index
//  cfg      sink       cfg_valid / cfg_ready cfg_data (top_k)
//
//  Logits are taken one per cycle. On the last one the sequencer takes over
//  and in_ready stays low: kk selection passes through the single store
//  read port, then per selected entry a load and a run of the weight unit
//  (one exp(-1) step per 256 of distance), then a load and compare per
//  entry for the draw search. Greedy (top_k 0 or 1) is one pass.
//  The result sits in an output register; a new vector may start loading
//  while it waits. Reset sets top_k to 1 and empties the vector.
// ----------------------------------------------------------------------------
module topk_softmax_sampler_top
    import tkss_pkg::*;
#(
    parameter int MAX_ITEMS = 65536,
    parameter int MAX_K     = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [LOGIT_W-1:0] logit,
    input  logic [DRAW_W-1:0]  random_draw,
    input  logic               last_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [TOKEN_W-1:0] token_index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TOPK_W-1:0]  cfg_data
);

    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int KW  = $clog2(MAX_K + 1);
    localparam int KAW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int TW  = WGT_W + KW;
    localparam int PW  = DRAW_W + TW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_LOADI = 4'd2;
    localparam logic [3:0] S_WAITI = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_SWAP1 = 4'd5;
    localparam logic [3:0] S_SWAP2 = 4'd6;
    localparam logic [3:0] S_WLOAD = 4'd7;
    localparam logic [3:0] S_WWAIT = 4'd8;
    localparam logic [3:0] S_WRUN  = 4'd9;
    localparam logic [3:0] S_SPREP = 4'd10;
    localparam logic [3:0] S_SLOAD = 4'd11;
    localparam logic [3:0] S_SWAIT = 4'd12;
    localparam logic [3:0] S_SCMP  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [TOPK_W-1:0]  top_k_reg;
    logic [KW-1:0]      kk_reg, kk_next;
    logic [KW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [AW-1:0]      jd_reg, jd_next;
    logic               pend_reg, pend_next;
    logic [LOGIT_W-1:0] best_v_reg, best_v_next;
    logic [TOKEN_W-1:0] best_x_reg, best_x_next;
    logic [AW-1:0]      best_pos_reg, best_pos_next;
    logic [LOGIT_W-1:0] cur_v_reg, cur_v_next;
    logic [TOKEN_W-1:0] cur_x_reg, cur_x_next;
    logic [LOGIT_W-1:0] maxv_reg, maxv_next;
    logic [DRAW_W-1:0]  draw_reg, draw_next;
    logic [TW-1:0]      total_reg, total_next;
    logic [TW-1:0]      run_reg, run_next;
    logic [PW-1:0]      prod_reg, prod_next;
    logic [TOKEN_W-1:0] tok_reg, tok_next;
    logic               out_valid_reg, out_valid_next;
    logic [TOKEN_W-1:0] token_reg, token_next;

    logic               st_we;
    logic [AW-1:0]      st_waddr;
    logic [LOGIT_W-1:0] st_wvalue;
    logic [TOKEN_W-1:0] st_windex;
    logic [AW-1:0]      st_raddr;
    logic [LOGIT_W-1:0] st_rvalue;
    logic [TOKEN_W-1:0] st_rindex;

    logic               exp_start;
    logic [15:0]        exp_dist;
    logic               exp_busy;
    logic               exp_done;
    logic [WGT_W-1:0]   exp_weight;

    logic [WGT_W-1:0]   wts_mem [MAX_K];
    logic [WGT_W-1:0]   wts_rd_reg;
    logic               wts_we;

    logic               in_xfer;
    logic [16:0]        diff;
    logic [PW-1:0]      run_scaled;
    int                 k_eff;
    int                 kk_int;

    tkss_store #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_store (
        .clk    (clk),
        .we     (st_we),
        .waddr  (st_waddr),
        .wvalue (st_wvalue),
        .windex (st_windex),
        .raddr  (st_raddr),
        .rvalue (st_rvalue),
        .rindex (st_rindex)
    );

    tkss_exp u_exp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (exp_start),
        .delta  (exp_dist),
        .busy   (exp_busy),
        .done   (exp_done),
        .weight (exp_weight)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign diff      = 17'($signed({maxv_reg[15], maxv_reg})
                           - $signed({st_rvalue[15], st_rvalue}));
    assign exp_dist  = diff[15:0];
    assign run_scaled = {run_reg, 16'd0} - PW'(run_reg);

    always_comb
    begin
        k_eff = (top_k_reg <= TOPK_W'(1)) ? 1 :
                ((int'(top_k_reg) > MAX_K) ? MAX_K : int'(top_k_reg));
        kk_int = (k_eff < int'(count_reg)) ? k_eff : int'(count_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        kk_next        = kk_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        jd_next        = jd_reg;
        pend_next      = pend_reg;
        best_v_next    = best_v_reg;
        best_x_next    = best_x_reg;
        best_pos_next  = best_pos_reg;
        cur_v_next     = cur_v_reg;
        cur_x_next     = cur_x_reg;
        maxv_next      = maxv_reg;
        draw_next      = draw_reg;
        total_next     = total_reg;
        run_next       = run_reg;
        prod_next      = prod_reg;
        tok_next       = tok_reg;
        out_valid_next = out_valid_reg;
        token_next     = token_reg;
        st_we          = 1'b0;
        st_waddr       = count_reg[AW-1:0];
        st_wvalue      = logit;
        st_windex      = TOKEN_W'(count_reg);
        st_raddr       = AW'(i_reg);
        exp_start      = 1'b0;
        wts_we         = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    // items beyond capacity are dropped
                    if (count_reg < CW'(MAX_ITEMS))
                    begin
                        st_we      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (last_item)
                    begin
                        draw_next  = random_draw;
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                kk_next    = KW'(kk_int);
                i_next     = '0;
                state_next = S_LOADI;
            end
            S_LOADI:
            begin
                state_next = S_WAITI;
            end
            S_WAITI:
            begin
                best_v_next   = st_rvalue;
                best_x_next   = st_rindex;
                best_pos_next = AW'(i_reg);
                cur_v_next    = st_rvalue;
                cur_x_next    = st_rindex;
                j_next        = CW'(i_reg) + 1'b1;
                pend_next     = 1'b0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                st_raddr = j_reg[AW-1:0];
                // strictly greater: the first of equal maxima is kept
                if (pend_reg && ($signed(st_rvalue) > $signed(best_v_reg)))
                begin
                    best_v_next   = st_rvalue;
                    best_x_next   = st_rindex;
                    best_pos_next = jd_reg;
                end
                if (j_reg < count_reg)
                begin
                    jd_next   = j_reg[AW-1:0];
                    j_next    = j_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                        state_next = S_SWAP1;
                end
            end
            S_SWAP1:
            begin
                st_we     = 1'b1;
                st_waddr  = AW'(i_reg);
                st_wvalue = best_v_reg;
                st_windex = best_x_reg;
                if (i_reg == '0)
                    maxv_next = best_v_reg;
                state_next = S_SWAP2;
            end
            S_SWAP2:
            begin
                st_we     = 1'b1;
                st_waddr  = best_pos_reg;
                st_wvalue = cur_v_reg;
                st_windex = cur_x_reg;
                if (i_reg == kk_reg - 1'b1)
                begin
                    i_next     = '0;
                    total_next = '0;
                    state_next = S_WLOAD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_LOADI;
                end
            end
            S_WLOAD:
            begin
                state_next = S_WWAIT;
            end
            S_WWAIT:
            begin
                exp_start  = 1'b1;
                state_next = S_WRUN;
            end
            S_WRUN:
            begin
                if (exp_done)
                begin
                    wts_we     = 1'b1;
                    total_next = total_reg + TW'(exp_weight);
                    if (i_reg == kk_reg - 1'b1)
                    begin
                        state_next = S_SPREP;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_WLOAD;
                    end
                end
            end
            S_SPREP:
            begin
                prod_next  = PW'(draw_reg) * PW'(total_reg);
                run_next   = '0;
                i_next     = '0;
                state_next = S_SLOAD;
            end
            S_SLOAD:
            begin
                state_next = S_SWAIT;
            end
            S_SWAIT:
            begin
                run_next   = run_reg + TW'(wts_rd_reg);
                tok_next   = st_rindex;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                // falls back to the last selected entry
                if ((prod_reg <= run_scaled) || (i_reg == kk_reg - 1'b1))
                    state_next = S_OUT;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SLOAD;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    token_next     = tok_reg;
                    count_next     = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            top_k_reg     <= TOPK_W'(1);
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            i_reg         <= '0;
            kk_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            i_reg         <= i_next;
            kk_reg        <= kk_next;
            if (cfg_valid && cfg_ready)
                top_k_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg        <= j_next;
        jd_reg       <= jd_next;
        best_v_reg   <= best_v_next;
        best_x_reg   <= best_x_next;
        best_pos_reg <= best_pos_next;
        cur_v_reg    <= cur_v_next;
        cur_x_reg    <= cur_x_next;
        maxv_reg     <= maxv_next;
        draw_reg     <= draw_next;
        total_reg    <= total_next;
        run_reg      <= run_next;
        prod_reg     <= prod_next;
        tok_reg      <= tok_next;
        token_reg    <= token_next;
    end

    // weight store, one entry per selected logit
    always_ff @(posedge clk)
    begin
        if (wts_we)
            wts_mem[i_reg[KAW-1:0]] <= exp_weight;
        wts_rd_reg <= wts_mem[i_reg[KAW-1:0]];
    end

    assign out_valid   = out_valid_reg;
    assign token_index = token_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_exp_only_in_wrun: assert property (@(posedge clk) disable iff (!rst_n)
        exp_busy |-> (state_reg == S_WRUN))
        else $error("weight unit running outside weight phase");

    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_SCMP || state_reg == S_WRUN)
        |-> (i_reg < kk_reg))
        else $error("pass index beyond selected count");

    a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

endmodule

// ===== tb/topk_softmax_sampler_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_softmax_sampler_top_tb - self-checking bench for the top-k sampler
// Drives logit vectors through the valid/ready input channel under several
// top_k settings and checks each token_index against a local predictor
// (argmax, selection passes, exp weights and draw search). A short table of
// directed vectors comes first, then two overflow vectors, then random traffic
// with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module topk_softmax_sampler_top_tb;
    import tkss_pkg::*;

    localparam int NSTORE   = 512;   // store depth for this bench, keeps overflow cheap
    localparam int NK       = 64;
    localparam int NO_TOK   = -1;    // row with no typed expectation
    localparam int N_RANDOM = 750;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [TOPK_W-1:0] k;
        logic [15:0]       lg;
        logic [15:0]       dr;
        logic              lst;
        int                tok;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [LOGIT_W-1:0] logit = '0;
    logic [DRAW_W-1:0]  random_draw = '0;
    logic               last_item = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [TOKEN_W-1:0] token_index;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [TOPK_W-1:0]  cfg_data = '0;

    int                 typed_tok = NO_TOK;
    int                 errors = 0;
    int                 tok_queue[$];
    int                 burst_left = 0;

    // predictor state
    logic signed [15:0] val_mem[NSTORE];
    int unsigned        pos_mem[NSTORE];
    int unsigned        n_held = 0;
    int unsigned        k_reg = 1;
    longint unsigned    exp_lut[257];

    topk_softmax_sampler_top #(.MAX_ITEMS(NSTORE), .MAX_K(NK)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .logit       (logit),
        .random_draw (random_draw),
        .last_item   (last_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .token_index (token_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        longint unsigned term, pos, neg;
        for (int t = 0; t <= 256; t++)
        begin
            term = 64'd1 << 32;
            pos  = term;
            neg  = 0;
            for (int n = 1; n <= 13; n++)
            begin
                term = term * t / (256 * n);
                if (n % 2) neg += term;
                else pos += term;
            end
            exp_lut[t] = pos - neg;
        end
    end

    function automatic int unsigned exp_weight(int unsigned d);
        longint unsigned w;
        longint unsigned r;
        int unsigned     q;
        w = exp_lut[d & 255];
        q = (d >> 8) & 255;
        for (int i = 0; i < q && w != 0; i++)
            w = (w * exp_lut[256]) >> 32;
        r = (w + 32768) >> 16;
        return (r > 65535) ? 65535 : int'(r);
    endfunction

    function automatic int unsigned choose_token(int unsigned draw);
        int unsigned        best, kk, kc, pi;
        int unsigned        wts[NK];
        longint unsigned    total, run;
        logic signed [15:0] tv;
        int                 maxv;
        best = 0;
        if (k_reg <= 1)
        begin
            for (int i = 1; i < n_held; i++)
                if (val_mem[i] > val_mem[best]) best = i;
            return pos_mem[best];
        end
        kc = (k_reg > NK) ? NK : k_reg;
        kk = (kc < n_held) ? kc : n_held;
        for (int i = 0; i < kk; i++)
        begin
            best = i;
            for (int j = i + 1; j < n_held; j++)
                if (val_mem[j] > val_mem[best]) best = j;
            tv = val_mem[i];
            pi = pos_mem[i];
            val_mem[i] = val_mem[best];
            pos_mem[i] = pos_mem[best];
            val_mem[best] = tv;
            pos_mem[best] = pi;
        end
        maxv  = val_mem[0];
        total = 0;
        for (int i = 0; i < kk; i++)
        begin
            wts[i] = exp_weight(maxv - int'(val_mem[i]));
            total += wts[i];
        end
        run = 0;
        for (int i = 0; i < kk; i++)
        begin
            run += wts[i];
            if (longint'(draw) * total <= run * 65535)
                return pos_mem[i];
        end
        return pos_mem[kk-1];
    endfunction

    // model and checker, sampled on the rising edge
    always @(posedge clk)
    begin
        int unsigned tok;
        int          want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                k_reg = cfg_data;
            if (in_valid && in_ready)
            begin
                if (n_held < NSTORE)
                begin
                    val_mem[n_held] = logit;
                    pos_mem[n_held] = n_held;
                    n_held++;
                end
                if (last_item)
                begin
                    tok = choose_token(random_draw) & 16'hFFFF;
                    n_held = 0;
                    tok_queue.push_back(typed_tok == NO_TOK ? int'(tok) : typed_tok);
                end
            end
            if (out_valid && out_ready)
            begin
                if (tok_queue.size() == 0)
                begin
                    $display("%0t token_index transfer unexpected: expected none got %0d",
                             $time, token_index);
                    errors++;
                end
                else
                begin
                    want = tok_queue.pop_front();
                    if (token_index !== want[15:0])
                    begin
                        $display("%0t token_index mismatch: expected %0d got %0d",
                                 $time, want, token_index);
                        errors++;
                    end
                end
            end
        end
    end

    // output back-pressure: free-running, random and long-stall stretches
    always @(negedge clk)
    begin
        int unsigned mode_left;
        int unsigned mode;
        if (mode_left == 0)
        begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic put_item(logic [15:0] lg, logic [15:0] dr, logic lst, int tok);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        logit       <= lg;
        random_draw <= dr;
        last_item   <= lst;
        typed_tok   <= tok;
        do @(posedge clk); while (!in_ready);
        burst_left--;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tok_queue.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_topk(logic [TOPK_W-1:0] k);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_logit(int unsigned spread);
        case (spread)
            0: return 16'($urandom_range(0, 3));
            1: return 16'(int'($urandom_range(0, 1023)) - 512);
            2: return 16'(int'($urandom_range(0, 8191)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    row_t dir_rows[] = '{
        // greedy after reset
        '{ROW_ITEM, 0,   16'h1234, 16'h0000, 1'b1, 0},
        '{ROW_ITEM, 0,   16'h8000, 16'h0000, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'h7FFF, 16'h0000, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'h7FFF, 16'hFFFF, 1'b1, 1},
        '{ROW_CFG,  0,   16'h0000, 16'h0000, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'hFFFB, 16'h0000, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'hFFFB, 16'h0000, 1'b1, 0},
        // top_k above the maximum, tied values
        '{ROW_CFG,  127, 16'h0000, 16'h0000, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'h0000, 16'h0000, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'h0000, 16'h0000, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'h0000, 16'h0000, 1'b1, 0},
        '{ROW_ITEM, 0,   16'h0100, 16'h0000, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'h0100, 16'h0000, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'h0080, 16'hFFFF, 1'b1, NO_TOK},
        // short vector with k = 2 and extreme distance
        '{ROW_CFG,  2,   16'h0000, 16'h0000, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'h8000, 16'hFFFF, 1'b1, 0},
        '{ROW_ITEM, 0,   16'h0064, 16'h8000, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'h8000, 16'h0000, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'h7FFF, 16'hFFFF, 1'b1, NO_TOK},
        '{ROW_CFG,  64,  16'h0000, 16'h0000, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'hFF00, 16'h7FFF, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'h0000, 16'h7FFF, 1'b0, NO_TOK},
        '{ROW_ITEM, 0,   16'hFF80, 16'h7FFF, 1'b1, NO_TOK}
    };

    initial
    begin
        int          sent;
        int unsigned vlen, spread;
        int unsigned k_pick;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            if (dir_rows[i].kind == ROW_CFG)
                write_topk(dir_rows[i].k);
            else
                put_item(dir_rows[i].lg, dir_rows[i].dr, dir_rows[i].lst, dir_rows[i].tok);

        // overflow: items past the store depth are dropped, last still answers
        for (int i = 0; i < NSTORE + 3; i++)
            put_item(rand_logit(3), 16'($urandom), i == NSTORE + 2, NO_TOK);
        write_topk(1);
        for (int i = 0; i < NSTORE + 2; i++)
            put_item(rand_logit(1), 16'($urandom), i == NSTORE + 1, NO_TOK);

        sent = 0;
        while (sent < N_RANDOM)
        begin
            case ($urandom_range(0, 7))
                0: k_pick = 0;
                1: k_pick = 1;
                2: k_pick = 2;
                3: k_pick = 64;
                4: k_pick = 127;
                default: k_pick = $urandom_range(0, 127);
            endcase
            write_topk(k_pick[TOPK_W-1:0]);
            for (int v = 0; v < 15 && sent < N_RANDOM; v++)
            begin
                vlen   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
                                                      : $urandom_range(1, 16);
                spread = $urandom_range(0, 3);
                for (int i = 0; i < vlen; i++)
                begin
                    put_item(rand_logit(spread), 16'($urandom), i == vlen - 1, NO_TOK);
                    sent++;
                end
            end
        end

        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("FAIL");
        $finish;
    end

endmodule
